[design/gtgv_pkg.sv]
// ----------------------------------------------------------------------------
// gtgv_pkg
// Shared types, constants and the CORDIC angle table for the go-to-goal unit.
// ----------------------------------------------------------------------------
`default_nettype none
package gtgv_pkg;

  localparam int CordicStages = 16;
  localparam int CW           = 43;  // CORDIC datapath width (33-bit delta << 8, plus growth)
  localparam int ZW           = 20;  // Q.16 angle accumulator width

  localparam logic [19:0] InvGain    = 20'd636751;
  localparam logic signed [ZW-1:0] PiQ16     = 20'sd205887;
  localparam logic signed [ZW-1:0] TwoPiQ16  = 20'sd411775;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [ZW-1:0] AlignTol  = 20'sd6554;
  localparam logic [23:0] GoalTol = 24'd65;
  localparam logic [23:0] LinMax  = 24'hFFFFFF;

  localparam logic [1:0] RegMaxLin  = 2'd0;
  localparam logic [1:0] RegMinLin  = 2'd1;
  localparam logic [1:0] RegMaxTurn = 2'd2;

  typedef struct packed {
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [15:0] current_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } pose_t;

  typedef struct packed {
    logic [23:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               goal_reached;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] data;
  } cfg_t;

  // atan(2^-i) in Q.16, rounded
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 20'sd51472;  1: r = 20'sd30385;  2: r = 20'sd16055;  3: r = 20'sd8150;
      4: r = 20'sd4091;   5: r = 20'sd2047;   6: r = 20'sd1024;   7: r = 20'sd512;
      8: r = 20'sd256;    9: r = 20'sd128;   10: r = 20'sd64;    11: r = 20'sd32;
      12: r = 20'sd16;   13: r = 20'sd8;     14: r = 20'sd4;     15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/gtgv_if.sv]
// ----------------------------------------------------------------------------
// gtgv_if
// Valid/ready channels: pose input, command output, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface gtgv_pose_if;
  logic valid;
  logic ready;
  gtgv_pkg::pose_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtgv_cmd_if;
  logic valid;
  logic ready;
  gtgv_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtgv_cfg_if;
  logic valid;
  logic ready;
  gtgv_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/gtgv_cordic.sv]
// ----------------------------------------------------------------------------
// gtgv_cordic
// Pipelined CORDIC vectoring: one register stage per iteration, with stall.
// ----------------------------------------------------------------------------
`default_nettype none
module gtgv_cordic (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire logic signed [gtgv_pkg::CW-1:0]   x_i,
  input  wire logic signed [gtgv_pkg::CW-1:0]   y_i,
  input  wire logic signed [gtgv_pkg::ZW-1:0]   z_i,
  input  wire logic signed [15:0]               head_i,
  output logic                                  valid_o,
  output logic signed [gtgv_pkg::CW-1:0]        x_o,
  output logic signed [gtgv_pkg::ZW-1:0]        z_o,
  output logic signed [15:0]                    head_o
);
  localparam int N = gtgv_pkg::CordicStages;

  logic                           v_q [N+1];
  logic signed [gtgv_pkg::CW-1:0] x_q [N+1];
  logic signed [gtgv_pkg::CW-1:0] y_q [N+1];
  logic signed [gtgv_pkg::ZW-1:0] z_q [N+1];
  logic signed [15:0]             h_q [N+1];

  always_comb begin
    v_q[0] = valid_i;
    x_q[0] = x_i;
    y_q[0] = y_i;
    z_q[0] = z_i;
    h_q[0] = head_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [gtgv_pkg::CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    // valid bit of this stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    // one micro-rotation toward y = 0
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_q[i+1] <= h_q[i];
        if (!y_q[i][gtgv_pkg::CW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + gtgv_pkg::atan_q16(i);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - gtgv_pkg::atan_q16(i);
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign x_o     = x_q[N];
  assign z_o     = z_q[N];
  assign head_o  = h_q[N];
endmodule
`default_nettype wire

[design/go_to_goal_velocity_unit.sv]
// ----------------------------------------------------------------------------
// go_to_goal_velocity_unit
// Differential-drive go-to-goal controller with a pipelined CORDIC core.
// ----------------------------------------------------------------------------
// Accepts one pose/goal transaction per clock while the output is not stalled,
// and returns one command per transaction, in order. The pipeline registers
// are input delta, quadrant fold, 16 CORDIC stages, gain multiply, saturate,
// wrap and clamp/output register; throughput is set by the fully unrolled CORDIC pipeline. The whole pipe
// advances only when the output register is empty or being read, so a
// stalled sink holds every stage. Configuration writes are always ready.
`default_nettype none
module go_to_goal_velocity_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gtgv_pose_if.sink   pose_in,
  gtgv_cmd_if.source  cmd_out,
  gtgv_cfg_if.sink    cfg_in
);
  localparam int CW = gtgv_pkg::CW;
  localparam int ZW = gtgv_pkg::ZW;

  logic        en;
  logic [23:0] max_lin_q, min_lin_q;
  logic [14:0] max_turn_q;

  // configuration registers
  assign cfg_in.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q  <= 24'd65536;
      min_lin_q  <= '0;
      max_turn_q <= 15'd8192;
    end else if (cfg_in.valid) begin
      unique case (cfg_in.data.index)
        gtgv_pkg::RegMaxLin:  max_lin_q  <= cfg_in.data.data;
        gtgv_pkg::RegMinLin:  min_lin_q  <= cfg_in.data.data;
        gtgv_pkg::RegMaxTurn: max_turn_q <= cfg_in.data.data[14:0];
        default: ;
      endcase
    end
  end

  // output register backpressure drives the whole pipe
  logic out_v_q;
  assign en            = !out_v_q || cmd_out.ready;
  assign pose_in.ready = en;

  // stage 1: deltas
  logic              s1_v_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] h1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= pose_in.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= 33'(pose_in.data.goal_x) - 33'(pose_in.data.current_x);
      dy_q <= 33'(pose_in.data.goal_y) - 33'(pose_in.data.current_y);
      h1_q <= pose_in.data.current_heading;
    end
  end

  // stage 2: quadrant fold into the right half plane
  logic               s2_v_q;
  logic signed [CW-1:0] x2_q, y2_q;
  logic signed [ZW-1:0] z2_q;
  logic signed [15:0]   h2_q;
  logic signed [CW-1:0] xg, yg;
  assign xg = CW'(dx_q) <<< 8;
  assign yg = CW'(dy_q) <<< 8;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_q <= h1_q;
      if (!xg[CW-1]) begin
        x2_q <= xg; y2_q <= yg; z2_q <= '0;
      end else if (!yg[CW-1]) begin
        x2_q <= yg; y2_q <= -xg; z2_q <= gtgv_pkg::HalfPiQ16;
      end else begin
        x2_q <= -yg; y2_q <= xg; z2_q <= -gtgv_pkg::HalfPiQ16;
      end
    end
  end

  logic                 c_v;
  logic signed [CW-1:0] c_x;
  logic signed [ZW-1:0] c_z;
  logic signed [15:0]   c_h;
  gtgv_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_v_q),
    .x_i(x2_q), .y_i(y2_q), .z_i(z2_q), .head_i(h2_q),
    .valid_o(c_v), .x_o(c_x), .z_o(c_z), .head_o(c_h)
  );

  // stage M: gain product (x fits 42 bits nonnegative, split into two 21-bit halves)
  logic               m_v_q;
  logic [40:0]        plo_q, phi_q;
  logic signed [ZW-1:0] em_q;
  logic [41:0]        xu;
  assign xu = c_x[41:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else if (en) m_v_q <= c_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q <= 41'(xu[20:0] * gtgv_pkg::InvGain);
      phi_q <= 41'(xu[41:21] * gtgv_pkg::InvGain);
      em_q  <= c_z - (ZW'(c_h) <<< 3);
    end
  end

  // stage S: combine, round, saturate; first wrap pass
  logic               s_v_q;
  logic [23:0]        dist_q;
  logic signed [ZW-1:0] es_q;
  logic [62:0]        prod;
  logic [34:0]        dfull;
  logic signed [ZW+1:0] w1a, w1b;
  assign prod  = (63'(phi_q) << 21) + 63'(plo_q) + (63'd1 << 27);
  assign dfull = prod[62:28];
  always_comb begin
    w1a = (ZW+2)'(em_q);
    if (w1a > (ZW+2)'(gtgv_pkg::PiQ16))  w1a = w1a - (ZW+2)'(gtgv_pkg::TwoPiQ16);
    w1b = w1a;
    if (w1b < -(ZW+2)'(gtgv_pkg::PiQ16)) w1b = w1b + (ZW+2)'(gtgv_pkg::TwoPiQ16);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_v_q <= 1'b0;
    else if (en) s_v_q <= m_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (dfull > 35'(gtgv_pkg::LinMax)) ? gtgv_pkg::LinMax : dfull[23:0];
      es_q   <= w1b[ZW-1:0];
    end
  end

  // stage W: second wrap pass
  logic               w_v_q;
  logic [23:0]        dist_w_q;
  logic signed [ZW-1:0] err_q;
  logic signed [ZW-1:0] w2a, w2b;
  always_comb begin
    w2a = es_q;
    if (w2a > gtgv_pkg::PiQ16)  w2a = w2a - gtgv_pkg::TwoPiQ16;
    w2b = w2a;
    if (w2b < -gtgv_pkg::PiQ16) w2b = w2b + gtgv_pkg::TwoPiQ16;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) w_v_q <= 1'b0;
    else if (en) w_v_q <= s_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_w_q <= dist_q;
      err_q    <= w2b;
    end
  end

  // output stage: clamp, speed select, result register
  gtgv_pkg::cmd_t res, out_q;
  logic signed [ZW-1:0] lim, tcl, trnd;
  always_comb begin
    lim  = ZW'({max_turn_q, 3'b000});
    tcl  = err_q;
    if (tcl > lim)  tcl = lim;
    if (tcl < -lim) tcl = -lim;
    trnd = (tcl + ZW'(4)) >>> 3;
    res.goal_reached = 1'b0;
    res.angular_cmd  = trnd[15:0];
    if (err_q > gtgv_pkg::AlignTol || err_q < -gtgv_pkg::AlignTol) begin
      res.linear_cmd = '0;
    end else if (dist_w_q < min_lin_q) begin
      res.linear_cmd = min_lin_q;
    end else begin
      res.linear_cmd = (dist_w_q < max_lin_q) ? dist_w_q : max_lin_q;
    end
    if (dist_w_q <= gtgv_pkg::GoalTol) begin
      res.linear_cmd   = '0;
      res.angular_cmd  = '0;
      res.goal_reached = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= w_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= res;
  end
  assign cmd_out.valid = out_v_q;
  assign cmd_out.data  = out_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !cmd_out.ready |=> out_v_q && $stable(out_q))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_in.ready == (!out_v_q || cmd_out.ready))
    else $error("input ready not tied to output stage");
  a_reached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.goal_reached |-> out_q.linear_cmd == '0 && out_q.angular_cmd == '0)
    else $error("reached with nonzero command");
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.angular_cmd <= 16'sd25736 && out_q.angular_cmd >= -16'sd25736)
    else $error("angular command out of range");
`endif
endmodule
`default_nettype wire

[tb/go_to_goal_velocity_unit_test.sv]
// ----------------------------------------------------------------------------
// go_to_goal_velocity_unit_test
// Drives pose/goal transactions with random gaps and sink stalls, predicts
// each velocity command and checks every result in order.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 22;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gtgv_pose_if pose_ch();
  gtgv_cmd_if  cmd_ch();
  gtgv_cfg_if  cfg_ch();

  go_to_goal_velocity_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .pose_in(pose_ch.sink), .cmd_out(cmd_ch.source), .cfg_in(cfg_ch.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers
  logic [23:0] max_lin, min_lin;
  logic [14:0] max_turn;

  gtgv_pkg::cmd_t expected_cmds[$];
  int   mismatches = 0;
  bit   stall_ok = 1'b1;
  int   idle_cycles = 0;
  int   stall_left = 0;

  const longint AtanTab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2, 1};

  function automatic gtgv_pkg::cmd_t predict_cmd(gtgv_pkg::pose_t p);
    longint x, y, z, t, err, lim, xs, ys;
    longint unsigned distance, lin;
    gtgv_pkg::cmd_t c;
    x = (longint'(p.goal_x) - longint'(p.current_x)) <<< 8;
    y = (longint'(p.goal_y) - longint'(p.current_y)) <<< 8;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin t = x; x = y; y = -t; z = 102944; end
      else begin t = x; x = -y; y = t; z = -102944; end
    end
    for (int i = 0; i < gtgv_pkg::CordicStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin x += ys; y -= xs; z += AtanTab[i]; end
      else begin x -= ys; y += xs; z -= AtanTab[i]; end
    end
    distance = (longint'(x) * 636751 + (64'd1 << 27)) >> 28;
    if (distance > 64'hFFFFFF) distance = 64'hFFFFFF;
    if (distance <= 65) begin
      c.linear_cmd = '0; c.angular_cmd = '0; c.goal_reached = 1'b1;
      return c;
    end
    err = z - (longint'(p.current_heading) <<< 3);
    for (int i = 0; i < 2; i++) begin
      if (err > 205887) err -= 411775;
      if (err < -205887) err += 411775;
    end
    lim = longint'(max_turn) << 3;
    t = err;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    t = (t + 4) >>> 3;
    if (err > 6554 || err < -6554) lin = 0;
    else if (distance < min_lin) lin = min_lin;
    else lin = (distance < max_lin) ? distance : max_lin;
    c.linear_cmd = lin[23:0];
    c.angular_cmd = t[15:0];
    c.goal_reached = 1'b0;
    return c;
  endfunction

  // sink side: random stalls, compare each transaction
  always @(posedge clk_i) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command %p", cmd_ch.data);
      end else begin
        gtgv_pkg::cmd_t e;
        e = expected_cmds.pop_front();
        if (e !== cmd_ch.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp lin=%0d ang=%0d reached=%0b got lin=%0d ang=%0d reached=%0b",
                     e.linear_cmd, e.angular_cmd, e.goal_reached, cmd_ch.data.linear_cmd,
                     cmd_ch.data.angular_cmd, cmd_ch.data.goal_reached);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      cmd_ch.ready <= 1'b0;
    end else if (stall_ok && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(1, 10) - 1;
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("** go_to_goal_velocity_unit: FAILED **");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_pose(gtgv_pkg::pose_t p);
    if (stall_ok && $urandom_range(0, 7) == 0) begin
      pose_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.data <= p;
    @(posedge clk_i);
    while (!pose_ch.ready) @(posedge clk_i);
    expected_cmds.push_back(predict_cmd(p));
  endtask

  task automatic drain_results();
    pose_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      gtgv_pkg::RegMaxLin:  max_lin = val;
      gtgv_pkg::RegMinLin:  min_lin = val;
      gtgv_pkg::RegMaxTurn: max_turn = val[14:0];
      default: ;
    endcase
  endtask

  function automatic gtgv_pkg::pose_t rand_pose(bit near);
    gtgv_pkg::pose_t p;
    p.current_x = $urandom;
    p.current_y = $urandom;
    p.current_heading = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 51472) - 25736);
    if (near) begin
      p.goal_x = p.current_x + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      p.goal_y = p.current_y + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end else begin
      p.goal_x = $urandom;
      p.goal_y = $urandom;
    end
    return p;
  endfunction

  function automatic gtgv_pkg::pose_t mk(int cx, int cy, int hd, int gx, int gy);
    gtgv_pkg::pose_t p;
    p.current_x = cx; p.current_y = cy; p.current_heading = hd;
    p.goal_x = gx; p.goal_y = gy;
    return p;
  endfunction

  // extremes of fields, goal at robot, odd headings, far goals
  task automatic test_directed();
    send_pose(mk(0, 0, 0, 0, 0));
    send_pose(mk(100, -100, 25736, 100, -100));
    send_pose(mk(0, 0, 0, 65536, 0));
    send_pose(mk(0, 0, 0, 40, 40));
    send_pose(mk(0, 0, 0, 0, 65536));
    send_pose(mk(0, 0, 0, -65536, 1));
    send_pose(mk(0, 0, 0, -65536, -1));
    send_pose(mk(0, 0, -25736, 0, -65536));
    send_pose(mk(0, 0, 32767, 65536, 65536));
    send_pose(mk(0, 0, -32768, 65536, -65536));
    send_pose(mk(0, 0, 800, 65536, 10000));
    send_pose(mk(32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_pose(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000));
    send_pose(mk(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_pose(mk(-1, -1, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pose(rand_pose($urandom_range(0, 3) != 0));
  endtask

  // several register settings including extremes and min above max
  task automatic test_settings();
    write_reg(gtgv_pkg::RegMaxLin, 24'hFFFFFF);
    write_reg(gtgv_pkg::RegMinLin, 24'd0);
    write_reg(gtgv_pkg::RegMaxTurn, 24'd25736);
    test_directed();
    test_random(300);
    write_reg(gtgv_pkg::RegMaxLin, 24'd0);
    write_reg(gtgv_pkg::RegMaxTurn, 24'd0);
    test_random(200);
    write_reg(gtgv_pkg::RegMaxLin, 24'd20000);
    write_reg(gtgv_pkg::RegMinLin, 24'd150000);
    write_reg(gtgv_pkg::RegMaxTurn, 24'h7FFF);
    test_random(250);
    write_reg(gtgv_pkg::RegMinLin, 24'hFFFFFF);
    write_reg(gtgv_pkg::RegMaxTurn, 24'd1);
    test_random(100);
    write_reg(gtgv_pkg::RegMaxLin, 24'($urandom));
    write_reg(gtgv_pkg::RegMinLin, 24'($urandom_range(0, 200000)));
    write_reg(gtgv_pkg::RegMaxTurn, 24'($urandom_range(0, 25736)));
    test_random(250);
  endtask

  initial begin
    max_lin = 24'd65536; min_lin = 24'd0; max_turn = 15'd8192;
    pose_ch.valid = 1'b0; pose_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150);
    drain_results();  // sender holds off until all results have come
    test_settings();
    stall_ok = 1'b0;
    test_random(200);
    drain_results();
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("** go_to_goal_velocity_unit: PASSED **");
    end else begin
      $display("** go_to_goal_velocity_unit: FAILED **");
    end
    $finish;
  end
endmodule
